// ===== rtl/core/crl_pkg.sv =====
// shared types and constants of the connection rate limiter
`default_nettype none

package crl_pkg;

	localparam int TABLE_ENTRIES = 64;
	localparam int TIME_BITS     = 48;
	localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int TSUM_W        = TIME_BITS + 1;
	localparam int ADDR_W        = 32;
	localparam int CNT_W         = 5;
	localparam int CFG_IDX_W     = 3;
	localparam int CFG_DATA_W    = 16;

	localparam logic [15:0] WINDOW_RST  = 16'd8000;
	localparam logic [3:0]  BURST_RST   = 4'd3;
	localparam logic [15:0] FAST_RST    = 16'd800;
	localparam logic [15:0] BLOCK_RST   = 16'd3000;
	localparam logic [11:0] PENALTY_RST = 12'd225;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_WINDOW  = 3'd0,
		REG_BURST   = 3'd1,
		REG_FAST    = 3'd2,
		REG_BLOCK   = 3'd3,
		REG_PENALTY = 3'd4
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_NEW      = 3'd0,
		ST_ACCEPT   = 3'd1,
		ST_BLOCKED  = 3'd2,
		ST_NEWBLOCK = 3'd3,
		ST_FULL     = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		CMD_HIT  = 2'd0,
		CMD_NEW  = 2'd1,
		CMD_FULL = 2'd2
	} cmd_kind_t;

	typedef struct packed {
		logic [15:0] window_ms;
		logic [3:0]  burst_limit;
		logic [15:0] fast_window_ms;
		logic [15:0] block_ms;
		logic [11:0] penalty_ms;
	} cfg_t;

	typedef struct packed {
		cmd_kind_t              kind;
		logic [IDX_W-1:0]       idx;
		logic [ADDR_W-1:0]      addr;
		logic [TIME_BITS-1:0]   now;
	} cmd_t;

	// table update sent from the back end to the front end's address store
	typedef struct packed {
		logic                   we;
		logic [IDX_W-1:0]       idx;
		logic [ADDR_W-1:0]      addr;
	} tbl_wr_t;

	typedef struct packed {
		logic [TIME_BITS-1:0]   last;
		logic [TIME_BITS-1:0]   blk_until;
		logic [CNT_W-1:0]       count;
	} rec_t;

endpackage

`default_nettype wire

// ===== rtl/core/connection_rate_limiter.sv =====
// top level of the per-source connection rate limiter
// an attempt is scanned against the whole address table, then its update runs in the back end;
//   the scan does not start while the previous update still occupies the back end
// a new attempt is taken only once the previous one has finished its table scan, and that
//   scan waits until the previous update has been committed
// the result beat waits in its own register, so the next attempt is scanned meanwhile
// reset: asynchronous, active low; clears all table valid bits at once and loads register defaults
`default_nettype none

module connection_rate_limiter
	import crl_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// attempt side
	input  wire logic                  push,
	output logic                       full,
	input  wire logic [ADDR_W-1:0]     source_addr,
	input  wire logic [TIME_BITS-1:0]  now_ms,
	// verdict side
	output logic                       empty,
	input  wire logic                  pop,
	output logic                       accepted,
	output logic [2:0]                 status,
	// register writes
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_t    cfg_q;
	logic    cfg_wr;

	// front to back command path
	logic    cmd_push;
	cmd_t    cmd_wr_data;
	logic    cmd_pop;
	cmd_t    cmd_head;
	logic    cmd_empty;
	logic    cmd_full;

	// back end status and table writes seen by the front end
	logic    back_busy;
	tbl_wr_t tbl_wr;

	// register writes are always taken; unknown indexes fall through
	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.window_ms      <= WINDOW_RST;
			cfg_q.burst_limit    <= BURST_RST;
			cfg_q.fast_window_ms <= FAST_RST;
			cfg_q.block_ms       <= BLOCK_RST;
			cfg_q.penalty_ms     <= PENALTY_RST;
		end else if (cfg_wr) begin
			case (reg_idx_t'(cfg_index))
				REG_WINDOW:  cfg_q.window_ms      <= cfg_data;
				REG_BURST:   cfg_q.burst_limit    <= cfg_data[3:0];
				REG_FAST:    cfg_q.fast_window_ms <= cfg_data;
				REG_BLOCK:   cfg_q.block_ms       <= cfg_data;
				REG_PENALTY: cfg_q.penalty_ms     <= cfg_data[11:0];
				default:     cfg_q                <= cfg_q;
			endcase
		end
	end

	// lookup: holds one attempt and scans the address table for it
	crl_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.source_addr (source_addr),
		.now_ms      (now_ms),
		.back_busy   (back_busy),
		.cmd_empty   (cmd_empty),
		.cmd_full    (cmd_full),
		.cmd_push    (cmd_push),
		.cmd_data    (cmd_wr_data),
		.tbl_wr      (tbl_wr)
	);

	// classified attempts wait here for the update engine
	crl_cmd_fifo u_cmd_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (cmd_push),
		.wr_data (cmd_wr_data),
		.rd_en   (cmd_pop),
		.rd_data (cmd_head),
		.empty   (cmd_empty),
		.full    (cmd_full)
	);

	// update engine: burst and block rules, record write-back, verdict register
	crl_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.cmd_empty (cmd_empty),
		.cmd_head  (cmd_head),
		.cmd_pop   (cmd_pop),
		.tbl_wr    (tbl_wr),
		.busy      (back_busy),
		.empty     (empty),
		.pop       (pop),
		.accepted  (accepted),
		.status    (status)
	);

endmodule

`default_nettype wire

// ===== rtl/core/crl_cmd_fifo.sv =====
// two-entry command queue between the lookup front end and the update back end
`default_nettype none

module crl_cmd_fifo
	import crl_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic wr_en,
	input  cmd_t      wr_data,
	input  wire logic rd_en,
	output cmd_t      rd_data,
	output logic      empty,
	output logic      full
);

	cmd_t       mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;

	logic do_wr;
	logic do_rd;

	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign empty   = (cnt_q == 2'd0);
	assign full    = (cnt_q == 2'd2);
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (do_wr) wr_ptr_q <= !wr_ptr_q;
			if (do_rd) rd_ptr_q <= !rd_ptr_q;
			case ({do_wr, do_rd})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) mem_q[wr_ptr_q] <= wr_data;
	end

endmodule

`default_nettype wire

// ===== rtl/core/crl_front.sv =====
// front end: takes attempts and scans the source table for a hit or a free slot
`default_nettype none

module crl_front
	import crl_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 push,
	output logic                      full,
	input  wire logic [ADDR_W-1:0]    source_addr,
	input  wire logic [TIME_BITS-1:0] now_ms,
	input  wire logic                 back_busy,
	input  wire logic                 cmd_empty,
	input  wire logic                 cmd_full,
	output logic                      cmd_push,
	output cmd_t                      cmd_data,
	input  tbl_wr_t                   tbl_wr
);

	typedef enum logic [1:0] {
		F_EMPTY,
		F_HOLD,
		F_SCAN
	} fstate_t;

	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

	fstate_t              state_q;
	logic [ADDR_W-1:0]    addr_q;
	logic [TIME_BITS-1:0] now_q;
	logic [TABLE_ENTRIES-1:0] valid_q;
	logic [IDX_W-1:0]     rd_idx_q;
	logic                 issue_done_q;
	logic                 cmp_vld_s1;
	logic [IDX_W-1:0]     cmp_idx_s1;
	logic [ADDR_W-1:0]    rd_data_s1;
	logic                 hit_q;
	logic [IDX_W-1:0]     hit_idx_q;
	logic                 free_q;
	logic [IDX_W-1:0]     free_idx_q;

	logic [ADDR_W-1:0]    addr_mem [TABLE_ENTRIES];

	logic cur_hit;
	logic cur_free;
	logic scan_end;
	logic issuing;
	logic fin_hit;
	logic fin_free;

	assign full     = (state_q != F_EMPTY);
	assign issuing  = (state_q == F_SCAN) && !issue_done_q;
	assign cur_hit  = cmp_vld_s1 && valid_q[cmp_idx_s1] && (rd_data_s1 == addr_q);
	assign cur_free = cmp_vld_s1 && !valid_q[cmp_idx_s1];
	assign scan_end = cmp_vld_s1 && (cmp_idx_s1 == LAST_IDX);
	assign fin_hit  = hit_q || cur_hit;
	assign fin_free = free_q || cur_free;
	assign cmd_push = scan_end;

	// first match wins, then lowest free slot
	always_comb begin
		cmd_data.addr = addr_q;
		cmd_data.now  = now_q;
		if (fin_hit) begin
			cmd_data.kind = CMD_HIT;
			cmd_data.idx  = hit_q ? hit_idx_q : cmp_idx_s1;
		end else if (fin_free) begin
			cmd_data.kind = CMD_NEW;
			cmd_data.idx  = free_q ? free_idx_q : cmp_idx_s1;
		end else begin
			cmd_data.kind = CMD_FULL;
			cmd_data.idx  = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= F_EMPTY;
			valid_q      <= '0;
			rd_idx_q     <= '0;
			issue_done_q <= 1'b0;
			cmp_vld_s1   <= 1'b0;
			cmp_idx_s1   <= '0;
			hit_q        <= 1'b0;
			hit_idx_q    <= '0;
			free_q       <= 1'b0;
			free_idx_q   <= '0;
		end else begin
			if (tbl_wr.we) valid_q[tbl_wr.idx] <= 1'b1;
			cmp_vld_s1 <= issuing;
			cmp_idx_s1 <= rd_idx_q;
			case (state_q)
				F_EMPTY: begin
					if (push) state_q <= F_HOLD;
				end
				F_HOLD: begin
					// table must be settled before the scan starts
					if (!back_busy && cmd_empty) begin
						state_q      <= F_SCAN;
						rd_idx_q     <= '0;
						issue_done_q <= 1'b0;
						hit_q        <= 1'b0;
						free_q       <= 1'b0;
					end
				end
				F_SCAN: begin
					if (issuing) begin
						if (rd_idx_q == LAST_IDX) issue_done_q <= 1'b1;
						else rd_idx_q <= rd_idx_q + IDX_W'(1);
					end
					if (cur_hit && !hit_q) begin
						hit_q     <= 1'b1;
						hit_idx_q <= cmp_idx_s1;
					end
					if (cur_free && !free_q) begin
						free_q     <= 1'b1;
						free_idx_q <= cmp_idx_s1;
					end
					if (scan_end) state_q <= F_EMPTY;
				end
				default: state_q <= F_EMPTY;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push && !full) begin
			addr_q <= source_addr;
			now_q  <= now_ms;
		end
	end

	always_ff @(posedge clk) begin
		if (tbl_wr.we) addr_mem[tbl_wr.idx] <= tbl_wr.addr;
		rd_data_s1 <= addr_mem[rd_idx_q];
	end

`ifndef SYNTHESIS
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_push |-> !cmd_full)
		else $error("command pushed into a full queue");
	a_scan_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == F_SCAN) |-> (!back_busy && !tbl_wr.we))
		else $error("table changed during a scan");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/crl_back.sv =====
// back end: reads the source record, applies the burst rules and posts the verdict
`default_nettype none

module crl_back
	import crl_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  cfg_t      cfg,
	input  wire logic cmd_empty,
	input  cmd_t      cmd_head,
	output logic      cmd_pop,
	output tbl_wr_t   tbl_wr,
	output logic      busy,
	output logic      empty,
	input  wire logic pop,
	output logic      accepted,
	output logic [2:0] status
);

	typedef enum logic [1:0] {
		B_IDLE,
		B_LOAD,
		B_FIN
	} bstate_t;

	localparam logic [TIME_BITS-1:0] TIME_MAX = '1;

	bstate_t              state_q;
	cmd_t                 cmd_q;
	rec_t                 rec_s1;
	logic                 blocked_s2;
	logic [TIME_BITS-1:0] gap_s2;
	logic [TIME_BITS-1:0] pen_sat_s2;
	logic [TIME_BITS-1:0] blk_sat_s2;
	logic [CNT_W-1:0]     count_s2;
	logic                 out_valid_q;
	logic                 accepted_q;
	status_t              status_q;

	rec_t                 rec_mem [TABLE_ENTRIES];

	logic [TSUM_W-1:0]    pen_sum;
	logic [TSUM_W-1:0]    blk_sum;
	logic [CNT_W-1:0]     c_next;
	logic                 in_win;
	logic                 in_fast;
	logic                 over;
	logic                 rec_we;
	rec_t                 rec_new;
	logic                 res_acc;
	status_t              res_st;

	assign cmd_pop  = (state_q == B_IDLE) && !cmd_empty && !out_valid_q;
	assign busy     = (state_q != B_IDLE);
	assign empty    = !out_valid_q;
	assign accepted = accepted_q;
	assign status   = status_q;

	// stage a: wide compares and saturating sums
	assign pen_sum = {1'b0, rec_s1.blk_until} + TSUM_W'(cfg.penalty_ms);
	assign blk_sum = {1'b0, cmd_q.now} + TSUM_W'(cfg.block_ms);

	// stage b: burst rules
	assign c_next  = count_s2 + CNT_W'(1);
	assign in_win  = gap_s2 <= TIME_BITS'(cfg.window_ms);
	assign in_fast = gap_s2 <= TIME_BITS'(cfg.fast_window_ms);
	assign over    = c_next > CNT_W'(cfg.burst_limit);

	always_comb begin
		rec_we            = 1'b0;
		rec_new.last      = cmd_q.now;
		rec_new.blk_until = rec_s1.blk_until;
		rec_new.count     = count_s2;
		res_acc           = 1'b1;
		res_st            = ST_ACCEPT;
		tbl_wr.we         = 1'b0;
		tbl_wr.idx        = cmd_q.idx;
		tbl_wr.addr       = cmd_q.addr;
		if (state_q == B_FIN) begin
			case (cmd_q.kind)
				CMD_FULL: begin
					res_st = ST_FULL;
				end
				CMD_NEW: begin
					rec_we            = 1'b1;
					tbl_wr.we         = 1'b1;
					rec_new.blk_until = '0;
					rec_new.count     = CNT_W'(1);
					res_st            = ST_NEW;
				end
				CMD_HIT: begin
					rec_we = 1'b1;
					if (blocked_s2) begin
						rec_new.last      = rec_s1.last;
						rec_new.blk_until = pen_sat_s2;
						res_acc           = 1'b0;
						res_st            = ST_BLOCKED;
					end else if (in_win) begin
						if (over) begin
							rec_new.count = '0;
							if (in_fast) begin
								rec_new.blk_until = blk_sat_s2;
								res_acc           = 1'b0;
								res_st            = ST_NEWBLOCK;
							end
						end else begin
							rec_new.count = c_next;
						end
					end else begin
						rec_new.count = CNT_W'(1);
					end
				end
				default: res_st = ST_FULL;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			out_valid_q <= 1'b0;
			accepted_q  <= 1'b0;
			status_q    <= ST_NEW;
		end else begin
			if (pop && out_valid_q) out_valid_q <= 1'b0;
			case (state_q)
				B_IDLE: begin
					if (cmd_pop) state_q <= B_LOAD;
				end
				B_LOAD: begin
					state_q <= B_FIN;
				end
				B_FIN: begin
					out_valid_q <= 1'b1;
					accepted_q  <= res_acc;
					status_q    <= res_st;
					state_q     <= B_IDLE;
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_pop) cmd_q <= cmd_head;
		if (state_q == B_LOAD) begin
			blocked_s2 <= rec_s1.blk_until > cmd_q.now;
			gap_s2     <= (cmd_q.now >= rec_s1.last) ? cmd_q.now - rec_s1.last : '0;
			pen_sat_s2 <= pen_sum[TIME_BITS] ? TIME_MAX : pen_sum[TIME_BITS-1:0];
			blk_sat_s2 <= blk_sum[TIME_BITS] ? TIME_MAX : blk_sum[TIME_BITS-1:0];
			count_s2   <= rec_s1.count;
		end
	end

	// record store: read with the queue head, written once per new or hit command
	always_ff @(posedge clk) begin
		if (rec_we) rec_mem[cmd_q.idx] <= rec_new;
		if (cmd_pop) rec_s1 <= rec_mem[cmd_head.idx];
	end

`ifndef SYNTHESIS
	a_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_FIN) |-> !out_valid_q)
		else $error("verdict would overwrite a waiting beat");
	a_full_no_store: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == B_FIN) && (cmd_q.kind == CMD_FULL)) |-> (!rec_we && !tbl_wr.we))
		else $error("untracked source written to the table");
`endif

endmodule

`default_nettype wire

// ===== tb/sv/connection_rate_limiter_test.sv =====
`timescale 1ns / 1ps
// self-checking testbench of the connection rate limiter, directed rows then random phases
module connection_rate_limiter_test;
	import crl_pkg::*;

	localparam logic [TIME_BITS-1:0] TIME_TOP = '1;
	// one attempt scans the whole table before its verdict comes out
	localparam int LATENCY      = TABLE_ENTRIES + 7;
	localparam int PHASES       = 8;
	localparam int PHASE_ITEMS  = 75;
	// phase that floods the table with mostly fresh sources to fill it up
	localparam int FLOOD_PHASE  = 5;
	// last phase runs with the clock close to the top of the time range
	localparam int TOP_PHASE    = PHASES - 1;
	localparam int POOL_SIZE    = 72;
	localparam int HOT_SOURCES  = 8;
	localparam int MAX_IDLE     = 14;
	localparam int TIMEOUT_NS   = 5_000_000;
	// register indexes with no register behind them
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  push = 1'b0;
	logic                  full;
	logic [ADDR_W-1:0]     source_addr = '0;
	logic [TIME_BITS-1:0]  now_ms = '0;
	logic                  empty;
	logic                  pop = 1'b0;
	logic                  accepted;
	logic [2:0]            status;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	connection_rate_limiter uut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.source_addr(source_addr),
		.now_ms(now_ms),
		.empty(empty),
		.pop(pop),
		.accepted(accepted),
		.status(status),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#TIMEOUT_NS;
		$display("Test completed with failures");
		$finish;
	end

	typedef struct {
		logic    acc;
		status_t st;
	} verdict_t;

	// one directed attempt; typed rows carry a verdict that is plain to see
	typedef struct packed {
		logic [ADDR_W-1:0]    addr;
		logic [TIME_BITS-1:0] now;
		logic                 typed;
		logic                 acc;
		status_t              st;
	} attempt_row_t;

	localparam int ROW_COUNT = 17;
	localparam attempt_row_t ATTEMPT_ROWS [ROW_COUNT] = '{
		// fresh table: both address extremes come in as new sources
		'{32'h0000_0000, 48'd0,     1'b1, 1'b1, ST_NEW},
		'{32'hFFFF_FFFF, 48'd0,     1'b1, 1'b1, ST_NEW},
		// fast burst on address zero, fourth attempt gets blocked
		'{32'h0000_0000, 48'd100,   1'b0, 1'b0, ST_NEW},
		'{32'h0000_0000, 48'd200,   1'b0, 1'b0, ST_NEW},
		'{32'h0000_0000, 48'd300,   1'b0, 1'b0, ST_NEW},
		// still inside the block: rejected, block grows by the penalty
		'{32'h0000_0000, 48'd400,   1'b1, 1'b0, ST_BLOCKED},
		// gap beyond the window restarts the count
		'{32'hFFFF_FFFF, 48'd9000,  1'b0, 1'b0, ST_NEW},
		// time going backwards counts as a zero gap
		'{32'hFFFF_FFFF, 48'd8999,  1'b0, 1'b0, ST_NEW},
		// block over, back to normal
		'{32'h0000_0000, 48'd4000,  1'b0, 1'b0, ST_NEW},
		// slow burst: count passes the limit but the gap is outside the fast window
		'{32'hFFFF_FFFF, 48'd10000, 1'b0, 1'b0, ST_NEW},
		'{32'hFFFF_FFFF, 48'd11000, 1'b0, 1'b0, ST_NEW},
		// burst at the top of the time range, block and penalty saturate
		'{32'h8000_0000, TIME_TOP - 48'd1000, 1'b1, 1'b1, ST_NEW},
		'{32'h8000_0000, TIME_TOP - 48'd1000, 1'b0, 1'b0, ST_NEW},
		'{32'h8000_0000, TIME_TOP - 48'd999,  1'b0, 1'b0, ST_NEW},
		'{32'h8000_0000, TIME_TOP - 48'd998,  1'b0, 1'b0, ST_NEW},
		'{32'h8000_0000, TIME_TOP - 48'd10,   1'b1, 1'b0, ST_BLOCKED},
		'{32'h8000_0000, TIME_TOP,            1'b0, 1'b0, ST_NEW}
	};

	// predictor copy of the registers
	logic [15:0] cfg_window  = WINDOW_RST;
	logic [3:0]  cfg_burst   = BURST_RST;
	logic [15:0] cfg_fast    = FAST_RST;
	logic [15:0] cfg_block   = BLOCK_RST;
	logic [11:0] cfg_penalty = PENALTY_RST;

	// predictor copy of the source table
	logic                 src_valid [TABLE_ENTRIES];
	logic [ADDR_W-1:0]    src_addr  [TABLE_ENTRIES];
	logic [TIME_BITS-1:0] src_last  [TABLE_ENTRIES];
	logic [TIME_BITS-1:0] src_until [TABLE_ENTRIES];
	logic [CNT_W-1:0]     src_count [TABLE_ENTRIES];

	verdict_t expected_verdicts [$];
	int mismatches = 0;
	// per phase switches for idle gaps on each side
	logic tx_stalls = 1'b1;
	logic rx_stalls = 1'b1;

	function automatic logic [TIME_BITS-1:0] time_sat_add(input logic [TIME_BITS-1:0] a,
			input logic [CFG_DATA_W-1:0] b);
		logic [TIME_BITS:0] s;
		s = {1'b0, a} + (TIME_BITS + 1)'(b);
		return s[TIME_BITS] ? TIME_TOP : s[TIME_BITS-1:0];
	endfunction

	// decides one attempt and updates the table copy the way the block does
	function automatic verdict_t rate_verdict(input logic [ADDR_W-1:0] addr,
			input logic [TIME_BITS-1:0] now);
		int hit;
		int free_slot;
		logic [TIME_BITS-1:0] gap;
		logic [CNT_W-1:0] cnt;
		verdict_t v;
		hit = -1;
		free_slot = -1;
		v.acc = 1'b1;
		v.st = ST_ACCEPT;
		for (int i = 0; i < TABLE_ENTRIES; i++) begin
			if (src_valid[i]) begin
				if (hit < 0 && src_addr[i] == addr)
					hit = i;
			end else if (free_slot < 0) begin
				free_slot = i;
			end
		end
		if (hit < 0) begin
			if (free_slot < 0) begin
				// table full: let it through untracked
				v.st = ST_FULL;
			end else begin
				src_valid[free_slot] = 1'b1;
				src_addr[free_slot]  = addr;
				src_last[free_slot]  = now;
				src_until[free_slot] = '0;
				src_count[free_slot] = CNT_W'(1);
				v.st = ST_NEW;
			end
		end else if (src_until[hit] > now) begin
			src_until[hit] = time_sat_add(src_until[hit], {4'd0, cfg_penalty});
			v.acc = 1'b0;
			v.st = ST_BLOCKED;
		end else begin
			gap = (now >= src_last[hit]) ? now - src_last[hit] : '0;
			src_last[hit] = now;
			if (gap <= TIME_BITS'(cfg_window)) begin
				cnt = src_count[hit] + CNT_W'(1);
				if (cnt > CNT_W'(cfg_burst)) begin
					src_count[hit] = '0;
					if (gap <= TIME_BITS'(cfg_fast)) begin
						src_until[hit] = time_sat_add(now, cfg_block);
						v.acc = 1'b0;
						v.st = ST_NEWBLOCK;
					end
				end else begin
					src_count[hit] = cnt;
				end
			end else begin
				src_count[hit] = CNT_W'(1);
			end
		end
		return v;
	endfunction

	// one attempt beat; push stays high when the next one follows right away
	task automatic send_attempt(input logic [ADDR_W-1:0] addr, input logic [TIME_BITS-1:0] now,
			input logic typed, input logic acc, input status_t st);
		int gap;
		verdict_t v;
		gap = tx_stalls ? $urandom_range(0, MAX_IDLE) : 0;
		if (gap != 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push <= 1'b1;
		source_addr <= addr;
		now_ms <= now;
		// full is stable between edges, so look at it mid-cycle
		@(negedge clk);
		while (full) @(negedge clk);
		@(posedge clk);
		v = rate_verdict(addr, now);
		if (typed) begin
			v.acc = acc;
			v.st = st;
		end
		expected_verdicts.push_back(v);
	endtask

	// register write beat, mirrored into the predictor with the block's masking
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(negedge clk);
		while (!cfg_ready) @(negedge clk);
		@(posedge clk);
		case (idx)
			REG_WINDOW:  cfg_window = data;
			REG_BURST:   cfg_burst = data[3:0];
			REG_FAST:    cfg_fast = data;
			REG_BLOCK:   cfg_block = data;
			REG_PENALTY: cfg_penalty = data[11:0];
			default: ;
		endcase
	endtask

	// hold off the sender until every verdict has been taken
	task automatic settle();
		push <= 1'b0;
		while (expected_verdicts.size() != 0) @(posedge clk);
		@(posedge clk);
	endtask

	// verdict side: random pops, each verdict checked against the oldest expectation
	task automatic drain_verdicts();
		int gap;
		verdict_t v;
		forever begin
			gap = rx_stalls ? $urandom_range(0, MAX_IDLE) : 0;
			if (gap != 0) begin
				pop <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			pop <= 1'b1;
			@(negedge clk);
			while (empty) @(negedge clk);
			if (expected_verdicts.size() == 0) begin
				$display("%0t: verdict with none expected, actual accepted %0b status %0d",
					$time, accepted, status);
				mismatches++;
			end else begin
				v = expected_verdicts.pop_front();
				if (accepted !== v.acc) begin
					$display("%0t: accepted mismatch, expected %0b, actual %0b",
						$time, v.acc, accepted);
					mismatches++;
				end
				if (status !== v.st) begin
					$display("%0t: status mismatch, expected %0d, actual %0d",
						$time, v.st, status);
					mismatches++;
				end
			end
			// the beat goes at this edge
			@(posedge clk);
		end
	endtask

	initial begin
		logic [ADDR_W-1:0] pool [POOL_SIZE];
		logic [ADDR_W-1:0] addr;
		logic [63:0] clock_ms;
		logic [63:0] step;
		logic [CFG_DATA_W-1:0] w, b, f, bl, pe;
		int r;
		for (int i = 0; i < TABLE_ENTRIES; i++)
			src_valid[i] = 1'b0;
		pool[0] = '0;
		pool[1] = '1;
		for (int i = 2; i < POOL_SIZE; i++)
			pool[i] = $urandom;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		fork
			drain_verdicts();
		join_none

		// directed rows under the reset register values
		foreach (ATTEMPT_ROWS[i])
			send_attempt(ATTEMPT_ROWS[i].addr, ATTEMPT_ROWS[i].now, ATTEMPT_ROWS[i].typed,
				ATTEMPT_ROWS[i].acc, ATTEMPT_ROWS[i].st);
		settle();

		clock_ms = 64'd20000;
		for (int p = 0; p < PHASES; p++) begin
			// register settings: zeros, all ones, a mix of extremes, else random
			case (p)
				1: begin
					w = '0; b = '0; f = '0; bl = '0; pe = '0;
				end
				2: begin
					w = '1; b = '1; f = '1; bl = '1; pe = '1;
				end
				3: begin
					w = '1; b = 16'd1; f = '0; bl = '1; pe = 16'h0FFF;
				end
				default: begin
					w = CFG_DATA_W'($urandom_range(0, 65535));
					// small limits so bursts happen, upper bits exercise the mask
					b = 16'($urandom_range(0, 4095) << 4) | 16'($urandom_range(1, 5));
					f = CFG_DATA_W'($urandom_range(0, w));
					bl = CFG_DATA_W'($urandom_range(0, 65535));
					pe = CFG_DATA_W'($urandom_range(0, 65535));
				end
			endcase
			write_reg(REG_WINDOW, w);
			write_reg(REG_BURST, b);
			write_reg(REG_FAST, f);
			write_reg(REG_BLOCK, bl);
			write_reg(REG_PENALTY, pe);
			// a write to a hole in the map must leave everything alone
			write_reg(CFG_IDX_W'($urandom_range(REG_SPARE_LO, REG_SPARE_HI)),
				CFG_DATA_W'($urandom_range(0, 65535)));
			cfg_valid <= 1'b0;

			tx_stalls = ($urandom_range(0, 3) != 0);
			rx_stalls = ($urandom_range(0, 3) != 0);

			// move the time base for the phase
			if (p == TOP_PHASE)
				clock_ms = TIME_TOP - 64'($urandom_range(0, 100000));
			else if (p == 4)
				clock_ms = clock_ms + {$urandom_range(0, 32767), $urandom};
			else
				clock_ms = clock_ms + 64'($urandom_range(0, 1 << 24));
			if (clock_ms > TIME_TOP)
				clock_ms = TIME_TOP;

			for (int n = 0; n < PHASE_ITEMS; n++) begin
				r = $urandom_range(0, 99);
				if (p == FLOOD_PHASE)
					addr = (r < 80) ? $urandom : pool[$urandom_range(0, HOT_SOURCES - 1)];
				else if (r < 75)
					addr = pool[$urandom_range(0, HOT_SOURCES - 1)];
				else if (r < 95)
					addr = pool[$urandom_range(0, POOL_SIZE - 1)];
				else
					addr = $urandom;

				// gaps around the fast window, the window, a block, or a long jump
				r = $urandom_range(0, 99);
				if (r < 95) begin
					if (r < 45)
						step = 64'($urandom_range(0, cfg_fast + 1));
					else if (r < 75)
						step = 64'($urandom_range(0, cfg_window + 1));
					else if (r < 90)
						step = 64'($urandom_range(0, cfg_block + 4 * cfg_penalty + 1));
					else
						step = 64'($urandom_range(0, 1 << 20));
					clock_ms = clock_ms + step;
					if (clock_ms > TIME_TOP)
						clock_ms = TIME_TOP;
				end else begin
					// occasional step back in time
					step = 64'($urandom_range(0, 2000));
					clock_ms = (clock_ms > step) ? clock_ms - step : 64'd0;
				end
				send_attempt(addr, clock_ms[TIME_BITS-1:0], 1'b0, 1'b0, ST_NEW);
			end
			settle();
		end

		// all verdicts in; watch a little longer for strays
		repeat (2 * LATENCY) @(posedge clk);
		if (mismatches == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/core/crl_pkg.sv
rtl/core/crl_cmd_fifo.sv
rtl/core/crl_front.sv
rtl/core/crl_back.sv
rtl/core/connection_rate_limiter.sv
tb/sv/connection_rate_limiter_test.sv
